@@ design/kssd_pkg.sv @@
// Shared types, constants and helpers for the keyed shift decryptor.
`timescale 1ns / 1ps

package kssd_pkg;

  localparam int AlphaSize = 26;
  localparam int IdxW      = 5;
  localparam int ShiftW    = 5;

  localparam logic [7:0] UPPER_A      = 8'd65;
  localparam logic [7:0] UPPER_END    = 8'd91;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [6:0] LOWER_A      = 7'd97;

  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_KEY     = 2'd1;
  localparam logic [1:0] FUNC_DECRYPT = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_in;
  } cipher_req_t;

  typedef struct packed {
    logic [6:0] plain_char;
    logic       bad_char;
  } plain_req_t;

  // A decrypt request that yields a result, handed from the key stage.
  typedef struct packed {
    logic            valid;
    logic            bad;
    logic            hit;
    logic [IdxW-1:0] pos_miss;
  } lookup_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_free;
  } flow_t;

  function automatic logic [IdxW-1:0] popcount26(input logic [AlphaSize-1:0] v);
    logic [IdxW-1:0] n;
    n = '0;
    for (int b = 0; b < AlphaSize; b++) begin
      n = n + IdxW'(v[b]);
    end
    return n;
  endfunction

endpackage

@@ design/kssd_if.sv @@
// Request channel interfaces: ciphertext in, plaintext out, shift register write.
`timescale 1ns / 1ps

interface kssd_in_if;
  logic                      valid;
  logic                      ready;
  kssd_pkg::cipher_req_t     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kssd_out_if;
  logic                      valid;
  logic                      ready;
  kssd_pkg::plain_req_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kssd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [kssd_pkg::ShiftW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/kssd_ram.sv @@
// Generic single-port RAM with registered read and read enable.
`timescale 1ns / 1ps

module kssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ design/kssd_key.sv @@
// Key state: letter mask and length, request accept, position memory access.
`timescale 1ns / 1ps

module kssd_key (
  input  logic                      clk,
  input  logic                      rst,
  kssd_in_if.sink                   cipher,
  input  kssd_pkg::flow_t           flow,
  output kssd_pkg::lookup_t         lookup,
  output logic                      ram_we,
  output logic                      ram_re,
  output logic [kssd_pkg::IdxW-1:0] ram_addr,
  output logic [kssd_pkg::IdxW-1:0] ram_wdata
);
  import kssd_pkg::*;

  logic [AlphaSize-1:0] mask;
  logic [AlphaSize-1:0] mask_next;
  logic [IdxW-1:0]      key_length;
  logic [IdxW-1:0]      key_length_next;

  logic                 accept;
  logic                 is_upper;
  logic [IdxW-1:0]      idx;
  logic                 in_key;
  logic [AlphaSize-1:0] below;
  logic [IdxW:0]        miss_sum;

  assign cipher.ready = flow.s1_free;
  assign accept       = cipher.valid && cipher.ready;

  assign is_upper = (cipher.data.char_in >= UPPER_A) && (cipher.data.char_in < UPPER_END);
  assign idx      = IdxW'(cipher.data.char_in - UPPER_A);
  assign in_key   = is_upper && mask[idx];
  assign below    = mask & ((AlphaSize'(1) << idx) - AlphaSize'(1));
  // Letters absent from the key follow it in alphabet order.
  assign miss_sum = {1'b0, key_length} + {1'b0, idx} - {1'b0, popcount26(below)};

  assign ram_addr  = idx;
  assign ram_wdata = key_length;

  always_comb begin
    mask_next       = mask;
    key_length_next = key_length;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    lookup.valid    = 1'b0;
    lookup.bad      = 1'b0;
    lookup.hit      = in_key;
    lookup.pos_miss = miss_sum[IdxW-1:0];
    if (accept) begin
      case (cipher.data.func)
        FUNC_CLEAR: begin
          mask_next       = '0;
          key_length_next = '0;
        end
        FUNC_KEY: begin
          if (is_upper && !in_key && (key_length < IdxW'(AlphaSize))) begin
            mask_next[idx]  = 1'b1;
            key_length_next = key_length + 1'b1;
            ram_we          = 1'b1;
          end
        end
        FUNC_DECRYPT: begin
          if (cipher.data.char_in != NEWLINE_BYTE) begin
            lookup.valid = 1'b1;
            lookup.bad   = !is_upper;
            ram_re       = is_upper;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      key_length <= '0;
    end else begin
      mask       <= mask_next;
      key_length <= key_length_next;
    end
  end

endmodule

@@ design/kssd_decode.sv @@
// Shift register, position select, unshift and plaintext output register.
`timescale 1ns / 1ps

module kssd_decode (
  input  logic                      clk,
  input  logic                      rst,
  kssd_cfg_if.sink                  cfg,
  input  kssd_pkg::lookup_t         lookup,
  input  logic [kssd_pkg::IdxW-1:0] ram_rdata,
  output kssd_pkg::flow_t           flow,
  kssd_out_if.source                plain
);
  import kssd_pkg::*;

  logic [ShiftW-1:0] shift_amount;
  logic              s1_valid;
  logic              s1_bad;
  logic              s1_hit;
  logic [IdxW-1:0]   s1_pos_miss;
  logic              s1_move;
  logic              out_valid;
  plain_req_t        out_data;
  plain_req_t        out_data_next;

  logic [ShiftW-1:0] s_mod;
  logic [IdxW-1:0]   pos;
  logic [IdxW-1:0]   plain_idx;

  assign cfg.ready     = 1'b1;
  assign s1_move       = s1_valid && (!out_valid || plain.ready);
  assign flow.s1_valid = s1_valid;
  assign flow.s1_free  = !s1_valid || s1_move;

  assign plain.valid = out_valid;
  assign plain.data  = out_data;

  always_comb begin
    s_mod = (shift_amount >= ShiftW'(AlphaSize)) ? shift_amount - ShiftW'(AlphaSize)
                                                 : shift_amount;
    pos   = s1_hit ? ram_rdata : s1_pos_miss;
    if (pos >= s_mod) begin
      plain_idx = pos - s_mod;
    end else begin
      plain_idx = pos + IdxW'(AlphaSize) - s_mod;
    end
    if (s1_bad) begin
      out_data_next.plain_char = '0;
      out_data_next.bad_char   = 1'b1;
    end else begin
      out_data_next.plain_char = LOWER_A + {2'b00, plain_idx};
      out_data_next.bad_char   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount <= '0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        shift_amount <= cfg.data;
      end
      if (lookup.valid) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (plain.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup.valid) begin
      s1_bad      <= lookup.bad;
      s1_hit      <= lookup.hit;
      s1_pos_miss <= lookup.pos_miss;
    end
    if (s1_move) begin
      out_data <= out_data_next;
    end
  end

endmodule

@@ design/keyword_shift_substitution_decrypt.sv @@
// Top level of the keyword-shifted substitution decryptor.
`timescale 1ns / 1ps
//
//  Channel  Dir  Payload                 Purpose
//  cipher   in   func, char_in           clear key, add key letter, decrypt letter
//  plain    out  plain_char, bad_char    one result per decrypted byte except newline
//  cfg      in   shift amount (5 bit)    rotation used at encryption
//
//  One request per cycle is accepted while cipher.ready is high; a result passes through
//  the key position memory read and the stage-1 registers, then the output register.
//  Key updates take effect at accept, so a decrypt right after a key add sees it.
//  Reset (rst, synchronous) empties the key and zeroes the shift; the position
//  memory needs no clearing because the letter mask decides whether a read is used.
//  A stalled output holds one result and one more in flight before cipher.ready drops.

module keyword_shift_substitution_decrypt (
  input  logic       clk,
  input  logic       rst,
  kssd_in_if.sink    cipher,
  kssd_cfg_if.sink   cfg,
  kssd_out_if.source plain
);
  import kssd_pkg::*;

  flow_t           flow;
  lookup_t         lookup;
  logic            ram_we;
  logic            ram_re;
  logic [IdxW-1:0] ram_addr;
  logic [IdxW-1:0] ram_wdata;
  logic [IdxW-1:0] ram_rdata;

  kssd_key u_key (
    .clk       (clk),
    .rst       (rst),
    .cipher    (cipher),
    .flow      (flow),
    .lookup    (lookup),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  kssd_ram #(
    .WIDTH (IdxW),
    .DEPTH (AlphaSize)
  ) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  kssd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .lookup    (lookup),
    .ram_rdata (ram_rdata),
    .flow      (flow),
    .plain     (plain)
  );

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    plain.valid && plain.data.bad_char |-> plain.data.plain_char == '0)
    else $error("bad_char result carries a nonzero letter");

  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    plain.valid && !plain.data.bad_char |->
      plain.data.plain_char >= LOWER_A && plain.data.plain_char < LOWER_A + 7'(AlphaSize))
    else $error("plaintext letter out of range");

  a_lookup_lands: assert property (@(posedge clk) disable iff (rst)
    lookup.valid |=> flow.s1_valid)
    else $error("decrypt request lost between key and decode stages");

  a_no_ram_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("position memory read and write in the same cycle");

endmodule
